/* design/modem_message_parser_assert.svh */
// Assertion macros shared by the modem message parser.
`ifndef MODEM_MESSAGE_PARSER_ASSERT_SVH
`define MODEM_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mmp_pkg.sv */
`timescale 1ns / 1ps

package mmp_pkg;

    localparam int BufDepth = 24;

    // message codes
    localparam logic [7:0] CodeStd     = 8'h50;
    localparam logic [7:0] CodeExt     = 8'h51;
    localparam logic [7:0] CodeLink    = 8'h53;
    localparam logic [7:0] CodeRecord  = 8'h57;
    localparam logic [7:0] CodeCleanup = 8'h58;
    localparam logic [7:0] CodeInfo    = 8'h60;

    // cmd1 values
    localparam logic [7:0] CmdSuccess  = 8'h06;
    localparam logic [7:0] CmdOn       = 8'h11;
    localparam logic [7:0] CmdFastOn   = 8'h12;
    localparam logic [7:0] CmdOff      = 8'h13;
    localparam logic [7:0] CmdFastOff  = 8'h14;
    localparam logic [7:0] CmdIncBegin = 8'h17;
    localparam logic [7:0] CmdIncEnd   = 8'h18;
    localparam logic [7:0] CmdSetBtnA  = 8'h01;
    localparam logic [7:0] CmdSetBtnB  = 8'h02;

    // message kinds
    localparam logic [4:0] KindOther    = 5'd0;
    localparam logic [4:0] KindAck      = 5'd1;
    localparam logic [4:0] KindSuccess  = 5'd2;
    localparam logic [4:0] KindOnBc     = 5'd3;
    localparam logic [4:0] KindOffBc    = 5'd5;
    localparam logic [4:0] KindFastOnBc = 5'd7;
    localparam logic [4:0] KindFastOffBc = 5'd9;
    localparam logic [4:0] KindIncBegin = 5'd11;
    localparam logic [4:0] KindIncEnd   = 5'd12;
    localparam logic [4:0] KindSetBtn   = 5'd13;
    localparam logic [4:0] KindLink     = 5'd14;
    localparam logic [4:0] KindRecord   = 5'd15;
    localparam logic [4:0] KindCleanup  = 5'd16;
    localparam logic [4:0] KindInfo     = 5'd17;

    typedef logic [BufDepth-1:0][7:0] msg_view_t;

    typedef struct packed {
        logic [7:0] stream_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  msg_code;
        logic        status;
        logic [4:0]  msg_kind;
        logic [23:0] addr_a;
        logic [23:0] addr_b;
        logic [7:0]  flags;
        logic [7:0]  cmd1;
        logic [7:0]  cmd2;
        logic [7:0]  group;
        logic [23:0] aux;
        logic [55:0] user_data_lo;
        logic [55:0] user_data_hi;
    } result_t;

    // capture -> decode / top
    typedef struct packed {
        logic idle;     // awaiting a code byte
        logic done;     // this word completes a result
        logic unknown;  // this word is an unknown code
    } cap_status_t;

    // total length including code byte; zero for unknown codes
    function automatic logic [4:0] msg_length(input logic [7:0] code);
        logic [4:0] len;
        case (code)
            CodeStd:     len = 5'd10;
            CodeExt:     len = 5'd24;
            CodeLink:    len = 5'd9;
            CodeRecord:  len = 5'd9;
            CodeCleanup: len = 5'd2;
            CodeInfo:    len = 5'd7;
            default:     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* design/mmp_stream_if.sv */
`timescale 1ns / 1ps

interface mmp_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/mmp_capture.sv */
`timescale 1ns / 1ps

module mmp_capture
    import mmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  stream_byte,
    output msg_view_t   view,
    output cap_status_t status
);

    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [7:0]  code_reg;
    logic [7:0]  code_next;
    logic [4:0]  pos_inc;
    logic [4:0]  len;
    msg_view_t   buf_reg;

    assign pos_inc = pos_reg + 5'd1;
    assign len     = msg_length(code_reg);

    // buffer with the incoming word dropped into its slot
    always_comb begin
        for (int i = 0; i < BufDepth; i++) begin
            view[i] = (pos_reg == 5'(i)) ? stream_byte : buf_reg[i];
        end
    end

    always_comb begin
        status.idle    = (pos_reg == 5'd0);
        status.unknown = status.idle && (msg_length(stream_byte) == 5'd0);
        status.done    = status.idle ? status.unknown : (pos_inc >= len);
    end

    always_comb begin
        pos_next  = pos_reg;
        code_next = code_reg;
        if (accept) begin
            if (status.idle) begin
                if (!status.unknown) begin
                    code_next = stream_byte;
                    pos_next  = 5'd1;
                end
            end else begin
                pos_next = status.done ? 5'd0 : pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 5'd0;
            code_reg <= 8'h00;
        end
        else
        begin
            pos_reg  <= pos_next;
            code_reg <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= view;
        end
    end

endmodule

/* design/mmp_decode.sv */
`timescale 1ns / 1ps

module mmp_decode
    import mmp_pkg::*;
(
    input  msg_view_t   view,
    input  cap_status_t status,
    output result_t     res
);

    logic [7:0] fl;
    logic [7:0] c1;
    logic       ack;
    logic       al;
    logic       bc;
    logic       dim_cmd;
    logic [4:0] base;

    assign fl  = view[7];
    assign c1  = view[8];
    assign ack = fl[5];
    assign al  = fl[6];
    assign bc  = fl[7];
    assign dim_cmd = (c1 inside {CmdOn, CmdOff, CmdFastOn, CmdFastOff});

    always_comb begin
        case (c1)
            CmdOn:     base = KindOnBc;
            CmdOff:    base = KindOffBc;
            CmdFastOn: base = KindFastOnBc;
            default:   base = KindFastOffBc;
        endcase
    end

    always_comb begin
        res = '0;
        res.msg_code = view[0];
        if (status.unknown) begin
            res.status = 1'b1;
        end else begin
            case (view[0])
                CodeStd, CodeExt: begin
                    res.addr_a = {view[1], view[2], view[3]};
                    res.addr_b = bc ? 24'h0 : {view[4], view[5], view[6]};
                    res.flags  = fl;
                    res.cmd1   = c1;
                    res.cmd2   = view[9];
                    if (ack) begin
                        res.msg_kind = KindAck;
                    end else if (c1 == CmdSuccess && bc && al) begin
                        res.msg_kind = KindSuccess;
                        res.group    = view[6];
                        res.aux      = {view[4], view[5], view[9]};
                    end else if (dim_cmd && al) begin
                        res.msg_kind = bc ? base : base + 5'd1;
                        res.group    = bc ? view[5] : view[9];
                    end else if (c1 == CmdIncBegin && al && bc) begin
                        res.msg_kind = KindIncBegin;
                        res.group    = view[5];
                        res.aux      = {16'h0, view[9]};
                    end else if (c1 == CmdIncEnd && al && bc) begin
                        res.msg_kind = KindIncEnd;
                        res.group    = view[5];
                    end else if (c1 == CmdSetBtnA || c1 == CmdSetBtnB) begin
                        res.msg_kind = KindSetBtn;
                        res.aux      = {view[4], view[5], view[6]};
                    end else begin
                        res.msg_kind = KindOther;
                    end
                    if (view[0] == CodeExt) begin
                        res.user_data_lo = {view[10], view[11], view[12], view[13],
                                            view[14], view[15], view[16]};
                        res.user_data_hi = {view[17], view[18], view[19], view[20],
                                            view[21], view[22], view[23]};
                    end
                end
                CodeLink, CodeRecord: begin
                    res.msg_kind = (view[0] == CodeLink) ? KindLink : KindRecord;
                    res.addr_a   = {view[3], view[4], view[5]};
                    res.flags    = view[1];
                    res.group    = view[2];
                    res.aux      = {view[6], view[7], view[8]};
                end
                CodeCleanup: begin
                    res.msg_kind = KindCleanup;
                    res.aux      = {16'h0, view[1]};
                end
                CodeInfo: begin
                    res.msg_kind = KindInfo;
                    res.addr_a   = {view[1], view[2], view[3]};
                    res.aux      = {view[4], view[5], view[6]};
                end
                default: begin
                    res.msg_kind = KindOther;
                end
            endcase
        end
    end

endmodule

/* design/modem_message_parser.sv */
`timescale 1ns / 1ps
// Modem message parser.
// byte_ch: one stream byte per word. The first word while idle is the
//   message code; known codes open a message that runs 2 to 24 words long,
//   code included. Unknown codes give an error result at once.
// result_ch: one word per complete message (or unknown code) carrying the
//   addresses, flags, commands, group, aux bytes, user data and kind.
// Throughput: one byte per cycle when ready. Each byte goes into the capture
//   buffer; the final byte of a message is merged into the buffer view and
//   decoded in the same cycle, so the result register loads on that edge.
// Latency: the result is valid the cycle after its last byte is accepted.
// Reset: position and code clear, block idles awaiting a code byte, the
//   result register is empty. Buffer contents are not cleared.
// Stall: a single result register sits at the output. byte_ch.ready stays
//   high while that register is empty or being drained this cycle; when the
//   receiver holds result_ch.ready low with a result pending, input stalls.
// No timeout: a partial message waits for its remaining bytes forever.
module modem_message_parser
    import mmp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    mmp_stream_if.sink      byte_ch,
    mmp_stream_if.source    result_ch
);

`include "modem_message_parser_assert.svh"

    msg_view_t   view;
    cap_status_t cap;
    result_t     dec;
    logic        accept;
    logic        emit;

    logic        res_valid_reg;
    logic        res_valid_next;
    result_t     res_reg;

    // output slot free now or drained this cycle
    assign byte_ch.ready = !res_valid_reg || result_ch.ready;
    assign accept        = byte_ch.valid && byte_ch.ready;
    assign emit          = accept && cap.done;

    mmp_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (byte_ch.data.stream_byte),
        .view        (view),
        .status      (cap)
    );

    mmp_decode u_decode (
        .view   (view),
        .status (cap),
        .res    (dec)
    );

    always_comb begin
        res_valid_next = res_valid_reg;
        if (emit) begin
            res_valid_next = 1'b1;
        end else if (result_ch.ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= dec;
        end
    end

    assign result_ch.valid = res_valid_reg;
    assign result_ch.data  = res_reg;

    // a pending result that is not taken must hold off the input
    `MMP_ASSERT_NOW(a_stall_blocks_input, res_valid_reg && !result_ch.ready, !byte_ch.ready, "input accepted over a pending result")
    // error results come only from idle, message results only mid-message
    `MMP_ASSERT_NOW(a_unknown_only_idle, emit, cap.unknown == cap.idle, "result source does not match parser position")
    // every result leaves the parser idle and the output loaded
    `MMP_ASSERT_NEXT(a_idle_after_emit, emit, cap.idle && res_valid_reg, "parser not idle or output empty after result")

endmodule
